/* rtl/core/pcd_pkg.sv */
package pcd_pkg;

  // Frame phase of the front end
  typedef enum logic [3:0] {
    PH_HUNT0   = 4'd0,
    PH_HUNT1   = 4'd1,
    PH_HUNT2   = 4'd2,
    PH_HUNT3   = 4'd3,
    PH_TYPE    = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CRC_HI  = 4'd8,
    PH_CRC_LO  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ID   = 2'd0,
    KIND_ENC  = 2'd1,
    KIND_FILE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEC_NONCE  = 2'd0,
    SEC_CIPHER = 2'd1,
    SEC_TAG    = 2'd2
  } section_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_CRC_FAIL = 2'd3
  } status_t;

  // Work the back end does for one classified byte
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SEED    = 3'd1,
    OP_ADD     = 3'd2,
    OP_PAYLOAD = 3'd3,
    OP_CRC_HI  = 3'd4,
    OP_CRC_LO  = 3'd5,
    OP_BAD_LEN = 3'd6
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PREAMBLE   = 3'd0,
    REG_TYPE_ID    = 3'd1,
    REG_TYPE_ENC   = 3'd2,
    REG_TYPE_FILE  = 3'd3,
    REG_MAX_ID     = 3'd4,
    REG_MAX_SEALED = 3'd5,
    REG_CRC_SEED   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] index;
    section_t    section;
    kind_t       kind;
  } item_t;

  typedef struct packed {
    logic [31:0] preamble_word;
    logic [7:0]  type_key_id;
    logic [7:0]  type_encrypted;
    logic [7:0]  type_file;
    logic [6:0]  max_id_length;
    logic [15:0] max_sealed_length;
    logic [15:0] crc_seed;
  } cfg_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // CRC-16/CCITT, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/preamble_crc_frame_deframer.sv */
// Byte-serial frame deframer. Each received byte on the in_ channel yields
// exactly one result on the out_ channel, one per clock when unstalled. The
// block hunts for the four-byte preamble (preamble_word, first byte in bits
// 31..24), reads a type byte, a big-endian 16-bit length, the payload and a
// big-endian CRC-16/CCITT (poly 0x1021, seeded from crc_seed at the type
// byte, no final xor) over type, length and payload. Payload bytes come out
// with their index, section (nonce/id, ciphertext, tag) and frame kind;
// frame_done with frame_status marks the last CRC byte or a rejected length.
// A front stage tracks framing and classifies each byte, a two-entry queue
// decouples it from the back stage, which runs the CRC and owns the output
// register. A request is queued, then loaded into the output register. The
// byte-wide back-stage CRC update allows one byte per cycle unless stalled.
// Registers are written through cfg_ (index 0..6 in list order, others
// ignored) and should only change while no frame traffic is in flight.
module preamble_crc_frame_deframer #(
  parameter int NONCE_BYTES = 12,
  parameter int TAG_BYTES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [1:0]  out_section,
  output logic [1:0]  out_frame_kind,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  pcd_pkg::cfg_t cfg_r;

  // handshake bookkeeping
  logic           q_full;
  logic           q_not_empty;
  logic           in_take;
  logic           out_load;
  logic           out_valid_r;
  pcd_pkg::item_t front_item;
  pcd_pkg::item_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_word     <= 32'h0000_0000;
      cfg_r.type_key_id       <= 8'd1;
      cfg_r.type_encrypted    <= 8'd2;
      cfg_r.type_file         <= 8'd3;
      cfg_r.max_id_length     <= 7'd64;
      cfg_r.max_sealed_length <= 16'd256;
      cfg_r.crc_seed          <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcd_pkg::REG_PREAMBLE:   cfg_r.preamble_word     <= cfg_data;
        pcd_pkg::REG_TYPE_ID:    cfg_r.type_key_id       <= cfg_data[7:0];
        pcd_pkg::REG_TYPE_ENC:   cfg_r.type_encrypted    <= cfg_data[7:0];
        pcd_pkg::REG_TYPE_FILE:  cfg_r.type_file         <= cfg_data[7:0];
        pcd_pkg::REG_MAX_ID:     cfg_r.max_id_length     <= cfg_data[6:0];
        pcd_pkg::REG_MAX_SEALED: cfg_r.max_sealed_length <= cfg_data[15:0];
        pcd_pkg::REG_CRC_SEED:   cfg_r.crc_seed          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // a request is taken whenever the queue has room
  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  // output register refills when empty or being drained
  assign out_load = q_not_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  pcd_front #(
    .NONCE_BYTES (NONCE_BYTES),
    .TAG_BYTES   (TAG_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_take),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .item    (front_item)
  );

  pcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_item (front_item),
    .full      (q_full),
    .pop       (out_load),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pcd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (out_load),
    .item          (q_head),
    .crc_seed      (cfg_r.crc_seed),
    .payload_valid (out_payload_valid),
    .payload_byte  (out_payload_byte),
    .payload_index (out_payload_index),
    .section       (out_section),
    .frame_kind    (out_frame_kind),
    .frame_done    (out_frame_done),
    .frame_status  (out_frame_status)
  );

endmodule

/* rtl/core/pcd_front.sv */
module pcd_front #(
  parameter int NONCE_BYTES = 12,
  parameter int TAG_BYTES   = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  input  pcd_pkg::cfg_t cfg,
  output pcd_pkg::item_t item
);

  localparam logic [15:0] SEALED_MIN = 16'(NONCE_BYTES + TAG_BYTES);
  localparam logic [15:0] NONCE_LEN  = 16'(NONCE_BYTES);
  localparam logic [15:0] TAG_LEN    = 16'(TAG_BYTES);

  pcd_pkg::phase_t phase_r, phase_nxt;
  pcd_pkg::kind_t  kind_r, kind_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [15:0]     count_r, count_nxt;
  logic [15:0]     tag_start_r, tag_start_nxt;

  logic [7:0]  want;
  logic [15:0] len_full;
  logic        len_bad;
  logic [15:0] count_inc;

  always_comb begin
    case (phase_r)
      pcd_pkg::PH_HUNT0: want = cfg.preamble_word[31:24];
      pcd_pkg::PH_HUNT1: want = cfg.preamble_word[23:16];
      pcd_pkg::PH_HUNT2: want = cfg.preamble_word[15:8];
      default:           want = cfg.preamble_word[7:0];
    endcase
  end

  assign len_full  = {len_r[15:8], rx_byte};
  assign count_inc = count_r + 16'd1;

  always_comb begin
    if (kind_r == pcd_pkg::KIND_ID) begin
      len_bad = len_full > {9'd0, cfg.max_id_length};
    end else begin
      len_bad = (len_full < SEALED_MIN) || (len_full > cfg.max_sealed_length);
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    tag_start_nxt = tag_start_r;
    case (phase_r)
      pcd_pkg::PH_HUNT0,
      pcd_pkg::PH_HUNT1,
      pcd_pkg::PH_HUNT2,
      pcd_pkg::PH_HUNT3: begin
        phase_nxt = (rx_byte == want) ? pcd_pkg::phase_t'(phase_r + 4'd1)
                                      : pcd_pkg::PH_HUNT0;
      end
      pcd_pkg::PH_TYPE: begin
        phase_nxt = pcd_pkg::PH_LEN_HI;
        if (rx_byte == cfg.type_key_id) begin
          kind_nxt = pcd_pkg::KIND_ID;
        end else if (rx_byte == cfg.type_encrypted) begin
          kind_nxt = pcd_pkg::KIND_ENC;
        end else if (rx_byte == cfg.type_file) begin
          kind_nxt = pcd_pkg::KIND_FILE;
        end else begin
          phase_nxt = pcd_pkg::PH_HUNT0;
        end
      end
      pcd_pkg::PH_LEN_HI: begin
        len_nxt   = {rx_byte, 8'h00};
        phase_nxt = pcd_pkg::PH_LEN_LO;
      end
      pcd_pkg::PH_LEN_LO: begin
        len_nxt       = len_full;
        count_nxt     = 16'd0;
        tag_start_nxt = len_full - TAG_LEN;
        if (len_bad) begin
          phase_nxt = pcd_pkg::PH_HUNT0;
        end else if (len_full == 16'd0) begin
          phase_nxt = pcd_pkg::PH_CRC_HI;
        end else begin
          phase_nxt = pcd_pkg::PH_PAYLOAD;
        end
      end
      pcd_pkg::PH_PAYLOAD: begin
        count_nxt = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = pcd_pkg::PH_CRC_HI;
        end
      end
      pcd_pkg::PH_CRC_HI: phase_nxt = pcd_pkg::PH_CRC_LO;
      default:            phase_nxt = pcd_pkg::PH_HUNT0;
    endcase
  end

  // classified byte for the back end
  always_comb begin
    item         = '0;
    item.data    = rx_byte;
    item.op      = pcd_pkg::OP_NONE;
    item.section = pcd_pkg::SEC_NONCE;
    item.kind    = pcd_pkg::KIND_ID;
    case (phase_r)
      pcd_pkg::PH_TYPE: begin
        if (rx_byte == cfg.type_key_id || rx_byte == cfg.type_encrypted ||
            rx_byte == cfg.type_file) begin
          item.op = pcd_pkg::OP_SEED;
        end
      end
      pcd_pkg::PH_LEN_HI: begin
        item.op   = pcd_pkg::OP_ADD;
        item.kind = kind_r;
      end
      pcd_pkg::PH_LEN_LO: begin
        item.op   = len_bad ? pcd_pkg::OP_BAD_LEN : pcd_pkg::OP_ADD;
        item.kind = kind_r;
      end
      pcd_pkg::PH_PAYLOAD: begin
        item.op    = pcd_pkg::OP_PAYLOAD;
        item.kind  = kind_r;
        item.index = count_r;
        if (kind_r != pcd_pkg::KIND_ID) begin
          if (count_r < NONCE_LEN) begin
            item.section = pcd_pkg::SEC_NONCE;
          end else if (count_r >= tag_start_r) begin
            item.section = pcd_pkg::SEC_TAG;
          end else begin
            item.section = pcd_pkg::SEC_CIPHER;
          end
        end
      end
      pcd_pkg::PH_CRC_HI: begin
        item.op   = pcd_pkg::OP_CRC_HI;
        item.kind = kind_r;
      end
      pcd_pkg::PH_CRC_LO: begin
        item.op   = pcd_pkg::OP_CRC_LO;
        item.kind = kind_r;
      end
      default: item.op = pcd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pcd_pkg::PH_HUNT0;
      kind_r      <= pcd_pkg::KIND_ID;
      len_r       <= '0;
      count_r     <= '0;
      tag_start_r <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      len_r       <= len_nxt;
      count_r     <= count_nxt;
      tag_start_r <= tag_start_nxt;
    end
  end

endmodule

/* rtl/core/pcd_queue.sv */
module pcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pcd_pkg::item_t head
);

  pcd_pkg::item_t                   entry_r [pcd_pkg::QUEUE_DEPTH];
  logic [pcd_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pcd_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pcd_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  localparam logic [pcd_pkg::QCNT_W-1:0] FULL_CNT =
    pcd_pkg::QCNT_W'(pcd_pkg::QUEUE_DEPTH);
  localparam logic [pcd_pkg::QPTR_W-1:0] LAST_PTR =
    pcd_pkg::QPTR_W'(pcd_pkg::QUEUE_DEPTH - 1);
  localparam logic [pcd_pkg::QCNT_W-1:0] CNT_ONE  = pcd_pkg::QCNT_W'(1);

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/pcd_back.sv */
module pcd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  pcd_pkg::item_t item,
  input  logic [15:0]    crc_seed,
  output logic           payload_valid,
  output logic [7:0]     payload_byte,
  output logic [15:0]    payload_index,
  output logic [1:0]     section,
  output logic [1:0]     frame_kind,
  output logic           frame_done,
  output logic [1:0]     frame_status
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;

  logic        pv_nxt, done_nxt;
  logic [7:0]  pb_nxt;
  logic [15:0] pi_nxt;
  logic [1:0]  sec_nxt, fk_nxt, st_nxt;
  logic        pv_r, done_r;
  logic [7:0]  pb_r;
  logic [15:0] pi_r;
  logic [1:0]  sec_r, fk_r, st_r;

  always_comb begin
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    pv_nxt     = 1'b0;
    pb_nxt     = '0;
    pi_nxt     = '0;
    sec_nxt    = pcd_pkg::SEC_NONCE;
    fk_nxt     = item.kind;
    done_nxt   = 1'b0;
    st_nxt     = pcd_pkg::ST_NONE;
    case (item.op)
      pcd_pkg::OP_SEED: begin
        crc_nxt = pcd_pkg::crc_byte(crc_seed, item.data);
      end
      pcd_pkg::OP_ADD: begin
        crc_nxt = pcd_pkg::crc_byte(crc_r, item.data);
      end
      pcd_pkg::OP_PAYLOAD: begin
        crc_nxt = pcd_pkg::crc_byte(crc_r, item.data);
        pv_nxt  = 1'b1;
        pb_nxt  = item.data;
        pi_nxt  = item.index;
        sec_nxt = item.section;
      end
      pcd_pkg::OP_CRC_HI: begin
        crc_hi_nxt = item.data;
      end
      pcd_pkg::OP_CRC_LO: begin
        done_nxt = 1'b1;
        st_nxt   = ({crc_hi_r, item.data} == crc_r) ? pcd_pkg::ST_GOOD
                                                     : pcd_pkg::ST_CRC_FAIL;
      end
      pcd_pkg::OP_BAD_LEN: begin
        done_nxt = 1'b1;
        st_nxt   = pcd_pkg::ST_BAD_LEN;
      end
      default: fk_nxt = pcd_pkg::KIND_ID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= '0;
      crc_hi_r <= '0;
    end else if (load) begin
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pv_r   <= pv_nxt;
      pb_r   <= pb_nxt;
      pi_r   <= pi_nxt;
      sec_r  <= sec_nxt;
      fk_r   <= fk_nxt;
      done_r <= done_nxt;
      st_r   <= st_nxt;
    end
  end

  assign payload_valid = pv_r;
  assign payload_byte  = pb_r;
  assign payload_index = pi_r;
  assign section       = sec_r;
  assign frame_kind    = fk_r;
  assign frame_done    = done_r;
  assign frame_status  = st_r;

endmodule

/* verif/pcd_frame_checker.sv */
`timescale 1ns / 100ps

package deframer_tb_pkg;

  localparam logic [15:0] CCITT_POLY = 16'h1021;

  // CRC-16/CCITT, one byte folded in bit by bit, MSB first
  function automatic logic [15:0] ccitt_add(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CCITT_POLY;
      end
    end
    return r;
  endfunction

endpackage

module pcd_frame_checker
  import pcd_pkg::*;
  import deframer_tb_pkg::*;
#(
  parameter int NONCE_BYTES = 12,
  parameter int TAG_BYTES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_payload_valid,
  input  logic [7:0]  out_payload_byte,
  input  logic [15:0] out_payload_index,
  input  logic [1:0]  out_section,
  input  logic [1:0]  out_frame_kind,
  input  logic        out_frame_done,
  input  logic [1:0]  out_frame_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          backlog
);

  typedef struct packed {
    logic        pv;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    section_t    sec;
    kind_t       kind;
    logic        done;
    status_t     status;
  } byte_result_t;

  localparam cfg_t POWER_ON = '{
    preamble_word: 32'h0, type_key_id: 8'd1, type_encrypted: 8'd2, type_file: 8'd3,
    max_id_length: 7'd64, max_sealed_length: 16'd256, crc_seed: 16'hFFFF
  };

  cfg_t         regs;
  phase_t       ph;
  kind_t        fkind;
  logic [15:0]  flen;
  logic [15:0]  fcount;
  logic [15:0]  crc_acc;
  logic [7:0]   crc_top;
  byte_result_t predicted_bytes[$];
  int           mismatches = 0;

  // advances the frame state by one received byte, returns its result
  function automatic byte_result_t deframe_byte(input logic [7:0] b);
    byte_result_t r;
    logic [7:0]   want;
    logic         known;
    logic         reject;
    r = '0;
    case (ph)
      PH_HUNT0, PH_HUNT1, PH_HUNT2, PH_HUNT3: begin
        want = 8'(regs.preamble_word >> (24 - 8 * int'(ph)));
        ph   = (b == want) ? phase_t'(ph + 4'd1) : PH_HUNT0;
      end
      PH_TYPE: begin
        known = 1'b1;
        if (b == regs.type_key_id) begin
          fkind = KIND_ID;
        end else if (b == regs.type_encrypted) begin
          fkind = KIND_ENC;
        end else if (b == regs.type_file) begin
          fkind = KIND_FILE;
        end else begin
          known = 1'b0;
        end
        if (known) begin
          crc_acc = ccitt_add(regs.crc_seed, b);
          ph      = PH_LEN_HI;
        end else begin
          ph = PH_HUNT0;
        end
      end
      PH_LEN_HI: begin
        r.kind  = fkind;
        flen    = {b, 8'h00};
        crc_acc = ccitt_add(crc_acc, b);
        ph      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        r.kind    = fkind;
        flen[7:0] = b;
        crc_acc   = ccitt_add(crc_acc, b);
        if (fkind == KIND_ID) begin
          reject = flen > {9'd0, regs.max_id_length};
        end else begin
          reject = int'(flen) < NONCE_BYTES + TAG_BYTES || flen > regs.max_sealed_length;
        end
        if (reject) begin
          r.done   = 1'b1;
          r.status = ST_BAD_LEN;
          ph       = PH_HUNT0;
        end else begin
          fcount = '0;
          ph     = (flen == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.kind  = fkind;
        r.pv    = 1'b1;
        r.pbyte = b;
        r.pidx  = fcount;
        if (fkind != KIND_ID) begin
          if (int'(fcount) < NONCE_BYTES) begin
            r.sec = SEC_NONCE;
          end else if (int'(fcount) >= int'(flen) - TAG_BYTES) begin
            r.sec = SEC_TAG;
          end else begin
            r.sec = SEC_CIPHER;
          end
        end
        crc_acc = ccitt_add(crc_acc, b);
        fcount  = fcount + 16'd1;
        if (fcount >= flen) begin
          ph = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        r.kind  = fkind;
        crc_top = b;
        ph      = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        r.kind   = fkind;
        r.done   = 1'b1;
        r.status = ({crc_top, b} == crc_acc) ? ST_GOOD : ST_CRC_FAIL;
        ph       = PH_HUNT0;
      end
      default: begin
        ph = PH_HUNT0;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    byte_result_t head;
    if (!rst_n) begin
      regs    = POWER_ON;
      ph      = PH_HUNT0;
      fkind   = KIND_ID;
      flen    = '0;
      fcount  = '0;
      crc_acc = '0;
      crc_top = '0;
      predicted_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_PREAMBLE:   regs.preamble_word     = cfg_data;
          REG_TYPE_ID:    regs.type_key_id       = cfg_data[7:0];
          REG_TYPE_ENC:   regs.type_encrypted    = cfg_data[7:0];
          REG_TYPE_FILE:  regs.type_file         = cfg_data[7:0];
          REG_MAX_ID:     regs.max_id_length     = cfg_data[6:0];
          REG_MAX_SEALED: regs.max_sealed_length = cfg_data[15:0];
          REG_CRC_SEED:   regs.crc_seed          = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_bytes.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          head = predicted_bytes.pop_front();
          check_field("payload_valid", 32'(head.pv), 32'(out_payload_valid));
          check_field("payload_byte", 32'(head.pbyte), 32'(out_payload_byte));
          check_field("payload_index", 32'(head.pidx), 32'(out_payload_index));
          check_field("section", 32'(head.sec), 32'(out_section));
          check_field("frame_kind", 32'(head.kind), 32'(out_frame_kind));
          check_field("frame_done", 32'(head.done), 32'(out_frame_done));
          check_field("frame_status", 32'(head.status), 32'(out_frame_status));
        end
      end
      if (in_valid && !in_stall) begin
        predicted_bytes.push_back(deframe_byte(in_rx_byte));
      end
    end
    fail_count <= mismatches;
    backlog    <= predicted_bytes.size();
  end

endmodule

/* verif/preamble_crc_frame_deframer_test.sv */
`timescale 1ns / 100ps

module preamble_crc_frame_deframer_test;
  import pcd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int NONCE_LEN         = 12;
  localparam int TAG_LEN           = 16;
  localparam int SEALED_MIN        = NONCE_LEN + TAG_LEN;
  localparam int SETTINGS_RUN      = 7;     // register settings in the random part
  localparam int BYTES_PER_SETTING = 70;    // ~700 requests overall with the directed part
  localparam int HOLD_OFF          = 400;   // one long receiver stall
  localparam int IDLE_LIMIT        = 4000;  // watchdog: cycles with no handshake at all

  localparam cfg_t POWER_ON = '{
    preamble_word: 32'h0, type_key_id: 8'd1, type_encrypted: 8'd2, type_file: 8'd3,
    max_id_length: 7'd64, max_sealed_length: 16'd256, crc_seed: 16'hFFFF
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic [1:0]  out_section;
  logic [1:0]  out_frame_kind;
  logic        out_frame_done;
  logic [1:0]  out_frame_status;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = 3'd0;
  logic [31:0] cfg_data   = 32'h0;

  int   fail_count;
  int   backlog;
  int   bytes_sent = 0;
  cfg_t shadow     = POWER_ON;  // registers as last written, for building frames
  logic squeeze    = 1'b0;      // asks the receiver for its one long hold-off
  bit   calm       = 1'b0;      // sender offers back to back while set

  preamble_crc_frame_deframer #(
    .NONCE_BYTES (NONCE_LEN),
    .TAG_BYTES   (TAG_LEN)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_section       (out_section),
    .out_frame_kind    (out_frame_kind),
    .out_frame_done    (out_frame_done),
    .out_frame_status  (out_frame_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  pcd_frame_checker #(
    .NONCE_BYTES (NONCE_LEN),
    .TAG_BYTES   (TAG_LEN)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_section       (out_section),
    .out_frame_kind    (out_frame_kind),
    .out_frame_done    (out_frame_done),
    .out_frame_status  (out_frame_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .backlog           (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none, sometimes short, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] preamble_byte(input int i);
    return shadow.preamble_word[8 * (3 - i) +: 8];
  endfunction

  // Kind the block will pick for a code: key-ID beats encrypted beats file
  function automatic kind_t kind_of(input logic [7:0] code);
    if (code == shadow.type_key_id) begin
      return KIND_ID;
    end else if (code == shadow.type_encrypted) begin
      return KIND_ENC;
    end
    return KIND_FILE;
  endfunction

  function automatic logic [7:0] foreign_code();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == shadow.type_key_id || b == shadow.type_encrypted ||
               b == shadow.type_file);
    return b;
  endfunction

  function automatic cfg_t setting_for(input int n);
    cfg_t s;
    s.preamble_word     = $urandom;
    s.type_key_id       = 8'($urandom);
    s.type_encrypted    = 8'($urandom);
    s.type_file         = 8'($urandom);
    s.max_id_length     = 7'($urandom_range(0, 127));
    s.max_sealed_length = 16'($urandom_range(SEALED_MIN - 2, 120));
    s.crc_seed          = 16'($urandom);
    case (n)
      0: begin  // power-on codes and limits, new preamble
        s.type_key_id       = 8'd1;
        s.type_encrypted    = 8'd2;
        s.type_file         = 8'd3;
        s.max_id_length     = 7'd64;
        s.max_sealed_length = 16'd256;
        s.crc_seed          = 16'hFFFF;
      end
      1: begin  // all-ones preamble, codes at the byte extremes, widest limits
        s.preamble_word     = 32'hFFFF_FFFF;
        s.type_key_id       = 8'h00;
        s.type_encrypted    = 8'hFF;
        s.type_file         = 8'h80;
        s.max_id_length     = 7'd127;
        s.max_sealed_length = 16'hFFFF;
        s.crc_seed          = 16'h0000;
      end
      2: begin  // key-ID shadows encrypted; tightest limits
        s.preamble_word     = 32'h0;
        s.type_encrypted    = s.type_key_id;
        s.type_file         = ~s.type_key_id;
        s.max_id_length     = 7'd0;
        s.max_sealed_length = 16'(SEALED_MIN);
      end
      3: begin  // encrypted shadows file; no sealed frame can fit
        s.type_file         = s.type_encrypted;
        s.max_sealed_length = 16'd0;
      end
      4: begin  // key-ID shadows file; id limit just past 64
        s.type_file     = s.type_key_id;
        s.max_id_length = 7'd65;
      end
      default: ;
    endcase
    return s;
  endfunction

  // One request; a random idle may go before it
  task automatic push_rx(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Stop offering and wait for every predicted result to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only written with the block idle; spare upper bits carry junk
  task automatic apply_setting(input cfg_t s);
    logic [31:0] junk;
    junk = $urandom;
    drain();
    write_reg(REG_PREAMBLE, s.preamble_word);
    write_reg(REG_TYPE_ID, {junk[31:8], s.type_key_id});
    write_reg(REG_TYPE_ENC, {junk[31:8], s.type_encrypted});
    write_reg(REG_TYPE_FILE, {junk[31:8], s.type_file});
    write_reg(REG_MAX_ID, {junk[31:7], s.max_id_length});
    write_reg(REG_MAX_SEALED, {junk[31:16], s.max_sealed_length});
    write_reg(REG_CRC_SEED, {junk[31:16], s.crc_seed});
    cfg_valid <= 1'b0;
    shadow = s;
  endtask

  task automatic send_preamble();
    for (int i = 0; i < 4; i++) begin
      push_rx(preamble_byte(i));
    end
  endtask

  // Preamble cut short by a wrong byte; the block ends up back at the start
  // of the hunt (the wrong byte is the first preamble byte where possible)
  task automatic broken_preamble(input int depth);
    logic [7:0] want;
    logic [7:0] b;
    for (int i = 0; i < depth; i++) begin
      push_rx(preamble_byte(i));
    end
    want = preamble_byte(depth);
    b    = (preamble_byte(0) != want) ? preamble_byte(0) : want ^ 8'($urandom_range(1, 255));
    push_rx(b);
  endtask

  // Whole frame, or just up to the length when the length will be refused
  task automatic send_frame(input logic [7:0] code, input logic [15:0] len,
                            input bit header_only, input bit spoil_crc,
                            input bit extreme_fill);
    logic [15:0] acc;
    logic [7:0]  b;
    send_preamble();
    acc = ccitt_add(shadow.crc_seed, code);
    push_rx(code);
    acc = ccitt_add(acc, len[15:8]);
    push_rx(len[15:8]);
    acc = ccitt_add(acc, len[7:0]);
    push_rx(len[7:0]);
    if (!header_only) begin
      for (int i = 0; i < int'(len); i++) begin
        b   = extreme_fill ? {8{i[0]}} : 8'($urandom);
        acc = ccitt_add(acc, b);
        push_rx(b);
      end
      if (spoil_crc) begin
        acc = acc ^ 16'($urandom_range(1, 65535));
      end
      push_rx(acc[15:8]);
      push_rx(acc[7:0]);
    end
  endtask

  // Mostly well-formed frames; the rest refused lengths, foreign types,
  // broken preambles and line noise. Every branch leaves the block hunting.
  task automatic random_frame();
    int          pick;
    int          top;
    logic [7:0]  code;
    logic [7:0]  b;
    logic [15:0] len;
    kind_t       k;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       code = shadow.type_key_id;
      1:       code = shadow.type_encrypted;
      default: code = shadow.type_file;
    endcase
    k = kind_of(code);
    if (pick < 78) begin
      if (k == KIND_ID) begin
        top = (shadow.max_id_length > 24 && $urandom_range(0, 7) != 0) ?
              24 : int'(shadow.max_id_length);
        len = 16'($urandom_range(0, top));
        send_frame(code, len, 1'b0, $urandom_range(0, 7) == 0, 1'b0);
      end else if (int'(shadow.max_sealed_length) >= SEALED_MIN) begin
        top = int'(shadow.max_sealed_length);
        top = ($urandom_range(0, 7) != 0) ? ((top > 48) ? 48 : top) :
              ((top > 96) ? 96 : top);
        len = 16'($urandom_range(SEALED_MIN, top));
        send_frame(code, len, 1'b0, $urandom_range(0, 7) == 0, 1'b0);
      end else begin
        send_frame(code, 16'($urandom), 1'b1, 1'b0, 1'b0);
      end
    end else if (pick < 86) begin
      if (k == KIND_ID) begin
        len = $urandom_range(0, 1) ? 16'hFFFF :
              16'(shadow.max_id_length) + 16'($urandom_range(1, 4));
      end else if ($urandom_range(0, 1) || shadow.max_sealed_length == 16'hFFFF) begin
        len = 16'($urandom_range(0, SEALED_MIN - 1));
      end else begin
        len = shadow.max_sealed_length + 16'd1;
      end
      send_frame(code, len, 1'b1, 1'b0, 1'b0);
    end else if (pick < 91) begin
      send_preamble();
      push_rx(foreign_code());
    end else if (pick < 96) begin
      broken_preamble($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom);
        if (b == preamble_byte(0)) begin
          b = ~b;
        end
        push_rx(b);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int phase_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: power-on registers (zero preamble, codes 1/2/3)
    send_frame(shadow.type_key_id, 16'd0, 1'b0, 1'b0, 1'b0);    // empty key-ID frame
    send_frame(shadow.type_key_id, 16'd2, 1'b0, 1'b1, 1'b1);    // 00/FF payload, bad CRC
    send_preamble();
    push_rx(8'hFF);                                              // foreign type byte
    broken_preamble(2);
    send_frame(shadow.type_key_id, 16'd65, 1'b1, 1'b0, 1'b0);   // key-ID over limit
    send_frame(shadow.type_key_id, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_frame(shadow.type_encrypted, 16'(SEALED_MIN - 1), 1'b1, 1'b0, 1'b0); // too short
    send_frame(shadow.type_file, 16'd257, 1'b1, 1'b0, 1'b0);    // sealed over limit
    send_frame(shadow.type_encrypted, 16'(SEALED_MIN), 1'b0, 1'b0, 1'b0);
    send_frame(shadow.type_file, 16'(SEALED_MIN + 1), 1'b0, 1'b1, 1'b0);

    // random: one register setting after another, each written while idle
    for (int n = 0; n < SETTINGS_RUN; n++) begin
      apply_setting(setting_for(n));
      if (n == 0) begin
        squeeze <= 1'b1;  // receiver holds off while the sender keeps offering
        calm = 1'b1;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_SETTING) begin
        random_frame();
        calm = ($urandom_range(0, 5) == 0);
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS preamble_crc_frame_deframer");
    end else begin
      $display("FAIL preamble_crc_frame_deframer");
    end
    $finish;
  end

  // Receiver: runs of acceptance and stalls of random length, plus one long
  // hold-off so the internal queue fills and the input backs up
  initial begin
    int  run;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any request, result or register write moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL preamble_crc_frame_deframer");
    $finish;
  end

endmodule
